// File: hdl/agslm_pkg.sv
`default_nettype none

package agslm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 10;
  localparam int LEVEL_W  = 16;
  localparam int PROD_W   = 26;  // signed sample times volume
  localparam int MAG_W    = 25;  // magnitude of that product
  localparam int QUO_W    = 19;  // magnitude divided by one hundred
  localparam int RECIP_W  = 26;
  localparam int RECIP_SHIFT = 32;
  localparam int MAX_CHUNK_DEF = 4096;

  localparam logic [VOL_W-1:0]    UNITY_GAIN = 10'd100;
  // ceil(2^32 / 100): exact floor division by 100 for magnitudes below 2^25.
  localparam logic [RECIP_W-1:0]  RECIP_K    = 26'd42949673;
  localparam logic [QUO_W-1:0]    POS_LIMIT  = 19'd32767;
  localparam logic [QUO_W-1:0]    NEG_LIMIT  = 19'd32768;
  localparam logic [SAMPLE_W-1:0] SAT_MAX    = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAT_MIN    = 16'h8000;

  localparam logic [0:0] REG_VOLUME = 1'd0;
  localparam logic [0:0] REG_PAUSED = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_RECIP,
    ST_ACC,
    ST_DIV,
    ST_PUT
  } state_t;

  typedef struct packed {
    logic take;
    logic mul;
    logic recip;
    logic acc;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic chunk_end;
  } stat_t;

  function automatic int sum_width(input int max_chunk);
    return $clog2(longint'(max_chunk) * 64'd32768 + 64'd1);
  endfunction

  function automatic int cnt_width(input int max_chunk);
    return $clog2(max_chunk + 1);
  endfunction

endpackage

`default_nettype wire

// File: hdl/audio_gain_saturate_level_meter_unit.sv
`default_nettype none

// Volume gain with a mean-absolute level meter. Each accepted item carries a
// signed 16-bit sample and a chunk-end mark. The sample is scaled by
// volume_percent / 100, truncated toward zero and saturated to 16 bits; a
// volume of exactly 100 passes it through untouched. Every item gives one
// result, except while paused, when items are taken and dropped with no
// effect. The block sums the magnitudes of the output samples and counts
// them (only the first MAX_CHUNK samples of a chunk are counted); the item
// marked as chunk end also carries level = sum / count, truncated, and
// restarts the sum. Items are worked one at a time: an ordinary item goes
// through the multiply, reciprocal and accumulate steps before its result is
// loaded into the output register, and a chunk-end item also runs the
// restoring divider, which retires one quotient bit per cycle. The output
// register lets a new item be accepted while the previous result is still
// waiting to be taken. Registers are written through cfg_we / cfg_index /
// cfg_wdata: index 0 is volume_percent (reset 100), index 1 is paused (reset
// 0). Write them only while the block is idle.

module audio_gain_saturate_level_meter_unit
  import agslm_pkg::*;
#(
  parameter int MAX_CHUNK = MAX_CHUNK_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] in_sample_in,
  input  wire logic                in_chunk_end,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [SAMPLE_W-1:0]      out_sample_out,
  output logic                     out_level_valid,
  output logic [LEVEL_W-1:0]       out_level,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [VOL_W-1:0]    cfg_wdata
);

  logic [VOL_W-1:0] vol_r;
  logic             paused_r;
  cmd_t             cmd;
  stat_t            stat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r    <= UNITY_GAIN;
      paused_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOLUME: vol_r    <= cfg_wdata;
        REG_PAUSED: paused_r <= cfg_wdata[0];
        default:    vol_r    <= vol_r;
      endcase
    end
  end

  // The controller sequences multiply, reciprocal, accumulate, divide and
  // output load; the datapath holds every value and performs each step.
  agslm_ctrl #(
    .MAX_CHUNK(MAX_CHUNK)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .paused   (paused_r),
    .stat     (stat),
    .cmd      (cmd)
  );

  agslm_dp #(
    .MAX_CHUNK(MAX_CHUNK)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .vol            (vol_r),
    .in_sample_in   (in_sample_in),
    .in_chunk_end   (in_chunk_end),
    .stat           (stat),
    .out_sample_out (out_sample_out),
    .out_level_valid(out_level_valid),
    .out_level      (out_level)
  );

  // A result is never loaded over one that is still stalled at the output.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a waiting result");

  // A paused item is dropped at once and the block stays ready.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && paused_r) |=> !in_stall)
    else $error("paused item was not dropped");

  // Results without a chunk end carry a zero level.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_level_valid) |-> (out_level == '0))
    else $error("level set on a result without chunk end");

  // The mean of magnitudes can never exceed the largest magnitude.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_level_valid) |-> (out_level <= LEVEL_W'(32768)))
    else $error("level above full scale");

endmodule

`default_nettype wire

// File: hdl/agslm_ctrl.sv
`default_nettype none

module agslm_ctrl
  import agslm_pkg::*;
#(
  parameter int MAX_CHUNK = MAX_CHUNK_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  wire logic  paused,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam int SUM_W  = sum_width(MAX_CHUNK);
  localparam int ITER_W = $clog2(SUM_W);

  state_t            state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !paused) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:   state_nxt = ST_RECIP;
      ST_RECIP: state_nxt = ST_ACC;
      ST_ACC: begin
        if (stat.chunk_end) begin
          state_nxt = ST_DIV;
          iter_nxt  = ITER_W'(SUM_W - 1);
        end else begin
          state_nxt = ST_PUT;
        end
      end
      ST_DIV: begin
        if (iter_r == '0) begin
          state_nxt = ST_PUT;
        end else begin
          iter_nxt = iter_r - 1'b1;
        end
      end
      ST_PUT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid && !paused;
      end
      ST_MUL:   cmd.mul      = 1'b1;
      ST_RECIP: cmd.recip    = 1'b1;
      ST_ACC:   cmd.acc      = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_PUT:   cmd.load_out = slot_free;
      default:  in_stall     = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/agslm_dp.sv
`default_nettype none

module agslm_dp
  import agslm_pkg::*;
#(
  parameter int MAX_CHUNK = MAX_CHUNK_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  input  wire logic [VOL_W-1:0]    vol,
  input  wire logic [SAMPLE_W-1:0] in_sample_in,
  input  wire logic                in_chunk_end,
  output stat_t                    stat,
  output logic [SAMPLE_W-1:0]      out_sample_out,
  output logic                     out_level_valid,
  output logic [LEVEL_W-1:0]       out_level
);

  localparam int SUM_W = sum_width(MAX_CHUNK);
  localparam int CNT_W = cnt_width(MAX_CHUNK);

  logic [SAMPLE_W-1:0]   samp_r;
  logic                  end_r;
  logic [PROD_W-1:0]     prod_r;
  logic [QUO_W-1:0]      q_r;
  logic                  neg_r;
  logic [SAMPLE_W-1:0]   o_r;
  logic [SUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      den_r;
  logic [CNT_W:0]        rem_r;
  logic [SUM_W-1:0]      quo_r;
  logic [SAMPLE_W-1:0]   sample_out_r;
  logic                  level_valid_r;
  logic [LEVEL_W-1:0]    level_r;

  logic [PROD_W:0]             prod_full;
  logic [PROD_W-1:0]           prod_neg;
  logic [MAG_W-1:0]            mag25;
  logic [MAG_W+RECIP_W-1:0]    recip_full;
  logic [SAMPLE_W-1:0]         o_val;
  logic [SAMPLE_W:0]           o_mag;
  logic                        room;
  logic [SUM_W-1:0]            sum_nxt;
  logic [CNT_W-1:0]            cnt_nxt;
  logic [CNT_W:0]              rem_sh;
  logic [CNT_W+1:0]            diff;
  logic                        fits;

  assign prod_full  = $signed(samp_r) * $signed({1'b0, vol});
  assign prod_neg   = -prod_r;
  assign mag25      = prod_r[PROD_W-1] ? prod_neg[MAG_W-1:0] : prod_r[MAG_W-1:0];
  assign recip_full = mag25 * RECIP_K;

  // Saturate the scaled value; unity gain passes the sample untouched.
  always_comb begin
    if (vol == UNITY_GAIN) begin
      o_val = samp_r;
    end else if (!neg_r) begin
      o_val = (q_r > POS_LIMIT) ? SAT_MAX : q_r[SAMPLE_W-1:0];
    end else begin
      o_val = (q_r >= NEG_LIMIT) ? SAT_MIN : (SAMPLE_W'(0) - q_r[SAMPLE_W-1:0]);
    end
  end

  assign o_mag = o_val[SAMPLE_W-1] ? ((SAMPLE_W+1)'(0) - {o_val[SAMPLE_W-1], o_val})
                                   : {1'b0, o_val};

  assign room    = cnt_r < CNT_W'(MAX_CHUNK);
  assign sum_nxt = room ? sum_r + SUM_W'(o_mag) : sum_r;
  assign cnt_nxt = room ? cnt_r + 1'b1 : cnt_r;

  // One quotient bit per step of the restoring divider.
  assign rem_sh = {rem_r[CNT_W-1:0], quo_r[SUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};
  assign fits   = !diff[CNT_W+1];

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      samp_r <= in_sample_in;
      end_r  <= in_chunk_end;
    end
    if (cmd.mul) begin
      prod_r <= prod_full[PROD_W-1:0];
    end
    if (cmd.recip) begin
      q_r   <= recip_full[RECIP_SHIFT+QUO_W-1:RECIP_SHIFT];
      neg_r <= prod_r[PROD_W-1];
    end
    if (cmd.acc) begin
      o_r   <= o_val;
      rem_r <= '0;
      quo_r <= sum_nxt;
      den_r <= cnt_nxt;
    end
    if (cmd.div_step) begin
      rem_r <= fits ? diff[CNT_W:0] : rem_sh;
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
    if (cmd.load_out) begin
      sample_out_r  <= o_r;
      level_valid_r <= end_r;
      level_r       <= end_r ? quo_r[LEVEL_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (cmd.acc) begin
      if (end_r) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

  assign stat.chunk_end  = end_r;
  assign out_sample_out  = sample_out_r;
  assign out_level_valid = level_valid_r;
  assign out_level       = level_r;

endmodule

`default_nettype wire

// File: tb/sv/audio_gain_saturate_level_meter_unit_test.sv
`timescale 1ns / 1ps

module audio_gain_saturate_level_meter_unit_test
  import agslm_pkg::*;
();

  // The block divides by the literal one hundred when it scales by a percentage.
  localparam int PERCENT = 100;
  // Only the first MAX_CHUNK samples of a chunk feed the level meter.
  localparam int CHUNK_LIMIT = MAX_CHUNK_DEF;
  // The divider makes a chunk-end item the slowest to reach the output register,
  // so this margin covers any work still in flight.
  localparam int DRAIN_CYCLES = 64;
  // The longest correct quiet stretch is a sender gap, plus the divider, plus
  // a receiver stall streak, and this limit lies well beyond it, so it only
  // trips when the block hangs.
  localparam int QUIET_LIMIT = 4000;

  // One result item as the block presents it.
  typedef struct packed {
    logic [SAMPLE_W-1:0] pcm;
    logic                has_level;
    logic [LEVEL_W-1:0]  level;
  } meter_result_t;

  // One row of the directed script. When the row is typed, its expectation is
  // written out by hand. Otherwise the gain model supplies it.
  typedef struct packed {
    logic [VOL_W-1:0]    vol;
    logic                pause;
    logic [SAMPLE_W-1:0] pcm;
    logic                chunk_last;
    logic                typed;
    meter_result_t       want;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [SAMPLE_W-1:0] in_sample_in = '0;
  logic                in_chunk_end = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SAMPLE_W-1:0] out_sample_out;
  logic                out_level_valid;
  logic [LEVEL_W-1:0]  out_level;
  logic                cfg_we = 1'b0;
  logic [0:0]          cfg_index = REG_VOLUME;
  logic [VOL_W-1:0]    cfg_wdata = '0;

  // This is the gain model's own copy of the registers and the meter state.
  logic [VOL_W-1:0] gain_vol = UNITY_GAIN;
  logic             pause_on = 1'b0;
  logic [27:0]      level_sum = '0;
  logic [12:0]      level_count = '0;

  // Results that the gain model has predicted and the block has not yet produced, oldest first.
  meter_result_t pending_results[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fault_count = 0;
  int items_sent = 0;
  int samples_checked = 0;
  int levels_checked = 0;
  int quiet_cycles = 0;

  // The directed script runs first. It covers the pass-through extremes, zero
  // and full gain with saturation at both rails, and truncation toward zero on
  // a negative product. It also covers the most negative output counted as
  // 32768, a two-sample mean, and items dropped while paused.
  script_row_t script [21] = '{
    '{UNITY_GAIN, 1'b0, 16'h7FFF,     1'b1, 1'b1, '{16'h7FFF,     1'b1, 16'd32767}},
    '{UNITY_GAIN, 1'b0, 16'h8000,     1'b1, 1'b1, '{16'h8000,     1'b1, 16'd32768}},
    '{UNITY_GAIN, 1'b0, 16'h0000,     1'b1, 1'b1, '{16'h0000,     1'b1, 16'd0}},
    '{UNITY_GAIN, 1'b0, 16'sd1234,    1'b0, 1'b1, '{16'sd1234,    1'b0, 16'd0}},
    '{UNITY_GAIN, 1'b0, -16'sd1234,   1'b1, 1'b1, '{-16'sd1234,   1'b1, 16'd1234}},
    '{10'd0,      1'b0, 16'h7FFF,     1'b1, 1'b1, '{16'h0000,     1'b1, 16'd0}},
    '{10'd0,      1'b0, 16'h8000,     1'b1, 1'b1, '{16'h0000,     1'b1, 16'd0}},
    '{10'd1023,   1'b0, 16'h7FFF,     1'b0, 1'b1, '{16'h7FFF,     1'b0, 16'd0}},
    '{10'd1023,   1'b0, 16'h8000,     1'b1, 1'b1, '{16'h8000,     1'b1, 16'd32767}},
    '{10'd1023,   1'b0, 16'hFFFF,     1'b1, 1'b1, '{-16'sd10,     1'b1, 16'd10}},
    '{10'd50,     1'b0, 16'sd3,       1'b0, 1'b0, '0},
    '{10'd50,     1'b0, -16'sd3,      1'b1, 1'b0, '0},
    '{10'd200,    1'b0, 16'sd16384,   1'b0, 1'b0, '0},
    '{10'd99,     1'b0, 16'h8000,     1'b1, 1'b0, '0},
    '{10'd99,     1'b1, 16'sd1000,    1'b1, 1'b0, '0},
    '{10'd99,     1'b1, -16'sd5,      1'b0, 1'b0, '0},
    '{10'd101,    1'b0, 16'sd100,     1'b1, 1'b0, '0},
    '{10'd1,      1'b0, 16'h7FFF,     1'b0, 1'b0, '0},
    '{10'd1,      1'b0, 16'h8000,     1'b1, 1'b0, '0},
    '{10'd1,      1'b0, 16'h5555,     1'b0, 1'b0, '0},
    '{10'd1,      1'b0, 16'hAAAA,     1'b1, 1'b0, '0}
  };

  audio_gain_saturate_level_meter_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample_in    (in_sample_in),
    .in_chunk_end    (in_chunk_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_out  (out_sample_out),
    .out_level_valid (out_level_valid),
    .out_level       (out_level),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, with a fresh decision on every falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // This task applies one accepted item to the gain model. A paused block drops
  // the item outright, so the task then gives no result and leaves the meter
  // untouched.
  task automatic apply_gain(input logic [SAMPLE_W-1:0] pcm, input logic chunk_last,
                            output bit produced, output meter_result_t r);
    int s;
    int p;
    int mag;
    logic [27:0] mean;
    produced = 1'b0;
    r = '0;
    if (!pause_on) begin
      s = int'($signed(pcm));
      if (gain_vol == UNITY_GAIN) begin
        p = s;
      end else begin
        // SystemVerilog division truncates toward zero, as the block must.
        p = (s * int'(gain_vol)) / PERCENT;
        if (p > 32767) begin
          p = 32767;
        end else if (p < -32768) begin
          p = -32768;
        end
      end
      mag = (p < 0) ? -p : p;
      // Samples past the count limit still come out but no longer feed the meter.
      if (level_count < CHUNK_LIMIT) begin
        level_sum = level_sum + 28'(mag);
        level_count = level_count + 13'd1;
      end
      r.pcm = p[SAMPLE_W-1:0];
      r.has_level = chunk_last;
      if (chunk_last) begin
        mean = level_sum / 28'(level_count);
        r.level = mean[LEVEL_W-1:0];
        level_sum = '0;
        level_count = '0;
      end
      produced = 1'b1;
    end
  endtask

  // This task presents one item and waits for the block to take it. The sender
  // idles at random before each item. Valid stays high between back-to-back
  // items, and the payload holds while the block stalls.
  task automatic send_item(input logic [SAMPLE_W-1:0] pcm, input logic chunk_last,
                           input logic typed, input meter_result_t typed_r);
    bit produced;
    meter_result_t r;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= pcm;
    in_chunk_end <= chunk_last;
    do @(posedge clk); while (in_stall);
    apply_gain(pcm, chunk_last, produced, r);
    if (produced) begin
      pending_results.push_back(typed ? typed_r : r);
      items_sent++;
    end
  endtask

  // This task stops sending, waits for every predicted result, and then lets
  // the divider run dry. Register writes are safe only after it returns.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [VOL_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == REG_VOLUME) begin
      gain_vol = val;
    end else begin
      pause_on = val[0];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // The volume pick leans toward the edges: mute, the smallest gain, both
  // neighbors of unity, unity itself and full scale.
  function automatic logic [VOL_W-1:0] pick_volume();
    case ($urandom_range(0, 7))
      0: return 10'd0;
      1: return 10'd1;
      2: return 10'd99;
      3: return UNITY_GAIN;
      4: return 10'd101;
      5: return 10'd1023;
      default: return VOL_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // Samples are a mix of the rails, small values of either sign and full-range
  // noise.
  function automatic logic [SAMPLE_W-1:0] pick_pcm();
    int v;
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: begin
        v = $urandom_range(0, 15);
        return $urandom_range(0, 1) ? SAMPLE_W'(-v) : SAMPLE_W'(v);
      end
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Each result the block hands over is checked field by field against the
  // oldest expectation.
  always @(posedge clk) begin
    meter_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected result: sample %0d level_valid %0b level %0d",
                   $signed(out_sample_out), out_level_valid, out_level);
        end
      end else begin
        want = pending_results.pop_front();
        samples_checked++;
        if (want.has_level) begin
          levels_checked++;
        end
        if (out_sample_out !== want.pcm || out_level_valid !== want.has_level ||
            out_level !== want.level) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: expected sample %0d level_valid %0b level %0d, got %0d %0b %0d",
                     $signed(want.pcm), want.has_level, want.level,
                     $signed(out_sample_out), out_level_valid, out_level);
          end
        end
      end
    end
  end

  // The watchdog ends the run when neither side moves an item and no register
  // is written for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [VOL_W-1:0] vol;
    logic pause;
    int count;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // The directed part runs under the first idling profile. A row whose
    // settings differ from the current ones first lets the block drain, then
    // writes only the registers that change.
    send_idle_pct = 34;
    stall_pct = 53;
    foreach (script[i]) begin
      if (script[i].vol != gain_vol || script[i].pause != pause_on) begin
        settle();
        if (script[i].vol != gain_vol) begin
          write_reg(REG_VOLUME, script[i].vol);
        end
        if (script[i].pause != pause_on) begin
          write_reg(REG_PAUSED, VOL_W'(script[i].pause));
        end
      end
      send_item(script[i].pcm, script[i].chunk_last, script[i].typed, script[i].want);
    end

    // The random part has three idling profiles: receiver-heavy, then
    // sender-heavy, then none. Each profile walks through several register
    // settings. Chunks end at random, so some chunks span a volume change or
    // a pause. A paused setting gets only a short burst, because the block
    // ignores those items.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 53 : 0;
      stall_pct = (phase == 0) ? 53 : (phase == 1) ? 34 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        vol = pick_volume();
        pause = ($urandom_range(0, 5) == 0);
        settle();
        write_reg(REG_VOLUME, vol);
        write_reg(REG_PAUSED, VOL_W'(pause));
        count = pause ? 12 : 70;
        for (int k = 0; k < count; k++) begin
          send_item(pick_pcm(), $urandom_range(0, 7) == 0, 1'b0, '0);
        end
      end
    end

    settle();
    $display("Run covered %0d items: %0d scaled samples and %0d chunk levels checked,",
             items_sent, samples_checked, levels_checked);
    $display("volumes from mute to full scale, rail samples and paused stretches.");
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fault_count,
               pending_results.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
